// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ===== sv/xpbe_pkg.sv =====
// ---------------------------------------------------------------------------
// xpbe_pkg
// Types and constants shared by the XTEA PCBC byte encryptor.
// ---------------------------------------------------------------------------
package xpbe_pkg;

  // XTEA schedule constants
  localparam logic [31:0] XTEA_DELTA = 32'h9E37_79B9;
  localparam logic [8:0]  MAX_ROUNDS = 9'd256;

  // Input action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    IDX_IV_LOW  = 3'd0,
    IDX_IV_HIGH = 3'd1,
    IDX_KEY0    = 3'd2,
    IDX_KEY1    = 3'd3,
    IDX_KEY2    = 3'd4,
    IDX_KEY3    = 3'd5,
    IDX_ROUNDS  = 3'd6
  } cfg_idx_t;

  // Cipher engine states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FIN
  } bk_state_t;

  // One block handed from packer to cipher engine
  typedef struct packed {
    logic [63:0] block;
    logic        fresh;
  } q_entry_t;

  // Configuration seen by the cipher engine
  typedef struct packed {
    logic [31:0]       iv_low;
    logic [31:0]       iv_high;
    logic [3:0][31:0]  key;
    logic [8:0]        rounds;
  } cfg_t;

  // Cipher engine status
  typedef struct packed {
    logic busy;
    logic load;
  } bk_stat_t;

endpackage

// ===== sv/xtea_pcbc_byte_encryptor_core.sv =====
// ---------------------------------------------------------------------------
// xtea_pcbc_byte_encryptor_core
// Packs plaintext bytes into 64-bit blocks and enciphers them with XTEA in
// PCBC mode; end of stream pads a partial block and restarts from the IV.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in      | to core   | in_valid / in_stall  | action, data_byte
//   out     | from core | out_valid / out_stall| cipher_low, cipher_high
//   cfg     | to core   | cfg_write            | cfg_index, cfg_data
//
// The packer takes a byte whenever the block queue is not full.
// The cipher engine applies n = min(round_count, 256) XTEA iterations to each block,
// one iteration per clock, and takes no new block until it is done.
// Synchronous reset sets control and config at once; queue storage, cipher datapath and output data are not reset.
// A stalled output holds the engine at its finish step; the queue then fills
// and in_stall rises.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module xtea_pcbc_byte_encryptor_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] cipher_low,
  output logic [31:0] cipher_high,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  xpbe_pkg::cfg_t     cfg;
  xpbe_pkg::q_entry_t wr_entry;
  xpbe_pkg::q_entry_t rd_entry;
  xpbe_pkg::bk_stat_t bk_stat;
  logic               in_accept;
  logic               q_push;
  logic               q_pop;
  logic               q_empty;
  logic               q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.iv_low  <= '0;
      cfg.iv_high <= '0;
      cfg.key     <= '0;
      cfg.rounds  <= xpbe_pkg::MAX_ROUNDS;
    end else if (cfg_write) begin
      case (xpbe_pkg::cfg_idx_t'(cfg_index))
        xpbe_pkg::IDX_IV_LOW:  cfg.iv_low  <= cfg_data;
        xpbe_pkg::IDX_IV_HIGH: cfg.iv_high <= cfg_data;
        xpbe_pkg::IDX_KEY0:    cfg.key[0]  <= cfg_data;
        xpbe_pkg::IDX_KEY1:    cfg.key[1]  <= cfg_data;
        xpbe_pkg::IDX_KEY2:    cfg.key[2]  <= cfg_data;
        xpbe_pkg::IDX_KEY3:    cfg.key[3]  <= cfg_data;
        xpbe_pkg::IDX_ROUNDS:  cfg.rounds  <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  // Hold input while the queue has no room
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  xpbe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .action    (action),
    .data_byte (data_byte),
    .push      (q_push),
    .entry     (wr_entry)
  );

  xpbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (wr_entry),
    .pop      (q_pop),
    .rd_entry (rd_entry),
    .empty    (q_empty),
    .full     (q_full)
  );

  xpbe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_entry     (rd_entry),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cipher_low  (cipher_low),
    .cipher_high (cipher_high),
    .stat        (bk_stat)
  );

  // Packer never pushes into a full queue
  `ASSERT_NEVER(a_push_full, clk, rst, q_push && q_full)
  // Engine only overwrites the output register once it is free
  `ASSERT_CLK(a_out_free, clk, rst, bk_stat.load |-> (!out_valid || !out_stall))
  // An idle engine picks up a waiting block at once
  `ASSERT_CLK(a_pickup, clk, rst, (!bk_stat.busy && !q_empty) |=> bk_stat.busy)

endmodule

// ===== sv/xpbe_queue.sv =====
// ---------------------------------------------------------------------------
// xpbe_queue
// Short FIFO of packed blocks between packer and cipher engine.
// ---------------------------------------------------------------------------
module xpbe_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  xpbe_pkg::q_entry_t wr_entry,
  input  logic               pop,
  output xpbe_pkg::q_entry_t rd_entry,
  output logic               empty,
  output logic               full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  xpbe_pkg::q_entry_t mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(DEPTH));
  assign rd_entry = mem[rd_ptr];

  // Store pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/xpbe_front.sv =====
// ---------------------------------------------------------------------------
// xpbe_front
// Byte packer: gathers bytes into 64-bit blocks, handles end of stream.
// ---------------------------------------------------------------------------
module xpbe_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               action,
  input  logic [7:0]         data_byte,
  output logic               push,
  output xpbe_pkg::q_entry_t entry
);

  logic [55:0] pending;
  logic [2:0]  byte_pos;
  logic        fresh;
  logic        is_end;
  logic [55:0] pending_next;

  assign is_end = (action == xpbe_pkg::ACT_END);

  // Emit on eighth byte, or on end with bytes pending
  assign push = accept && (is_end ? (byte_pos != 3'd0) : (byte_pos == 3'd7));

  // Build block: end pads with zero, bytes above byte_pos are already clear
  assign entry.block = is_end ? {8'h00, pending} : {data_byte, pending};
  assign entry.fresh = fresh;

  // Drop the byte into its lane
  always_comb begin
    pending_next = pending;
    for (int i = 0; i < 7; i++) begin
      if (byte_pos == 3'(i)) begin
        pending_next[i*8 +: 8] = data_byte;
      end
    end
  end

  // Hold packing state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= '0;
      byte_pos <= '0;
      fresh    <= 1'b1;
    end else if (accept) begin
      if (is_end) begin
        pending  <= '0;
        byte_pos <= '0;
        fresh    <= 1'b1;
      end else if (byte_pos == 3'd7) begin
        pending  <= '0;
        byte_pos <= '0;
        fresh    <= 1'b0;
      end else begin
        pending  <= pending_next;
        byte_pos <= byte_pos + 1'b1;
      end
    end
  end

endmodule

// ===== sv/xpbe_back.sv =====
// ---------------------------------------------------------------------------
// xpbe_back
// Cipher engine: PCBC chaining around an XTEA core, one cycle per round.
// ---------------------------------------------------------------------------
module xpbe_back (
  input  logic               clk,
  input  logic               rst,
  input  xpbe_pkg::cfg_t     cfg,
  input  logic               q_empty,
  input  xpbe_pkg::q_entry_t q_entry,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        cipher_low,
  output logic [31:0]        cipher_high,
  output xpbe_pkg::bk_stat_t stat
);

  xpbe_pkg::bk_state_t state;
  xpbe_pkg::bk_state_t state_next;

  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] total;
  logic [8:0]  count;
  logic [63:0] ptext;
  logic [31:0] chain_low;
  logic [31:0] chain_high;
  logic [8:0]  limit;
  logic        start;
  logic        step;
  logic        load;
  logic [31:0] base_low;
  logic [31:0] base_high;
  logic [31:0] a_next;
  logic [31:0] b_next;
  logic [31:0] total_next;

  // Round count above 256 saturates
  assign limit = cfg.rounds[8] ? xpbe_pkg::MAX_ROUNDS : cfg.rounds;

  // Chaining value: IV at the head of a stream
  assign base_low  = q_entry.fresh ? cfg.iv_low  : chain_low;
  assign base_high = q_entry.fresh ? cfg.iv_high : chain_high;

  // One full XTEA cycle
  assign total_next = total + xpbe_pkg::XTEA_DELTA;
  assign a_next = a + ((((b << 4) ^ (b >> 5)) + b) ^ (total + cfg.key[total[1:0]]));
  assign b_next = b + ((((a_next << 4) ^ (a_next >> 5)) + a_next)
                       ^ (total_next + cfg.key[total_next[12:11]]));

  // Next state and strobes
  always_comb begin
    state_next = state;
    start      = 1'b0;
    step       = 1'b0;
    load       = 1'b0;
    case (state)
      xpbe_pkg::BK_IDLE: begin
        if (!q_empty) begin
          start      = 1'b1;
          state_next = xpbe_pkg::BK_RUN;
        end
      end
      xpbe_pkg::BK_RUN: begin
        if (count == limit) begin
          state_next = xpbe_pkg::BK_FIN;
        end else begin
          step = 1'b1;
        end
      end
      xpbe_pkg::BK_FIN: begin
        if (!out_valid || !out_stall) begin
          load       = 1'b1;
          state_next = xpbe_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = xpbe_pkg::BK_IDLE;
      end
    endcase
  end

  assign q_pop     = start;
  assign stat.busy = (state != xpbe_pkg::BK_IDLE);
  assign stat.load = load;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xpbe_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Cipher datapath: load whitened block, then iterate rounds
  always_ff @(posedge clk) begin
    if (start) begin
      a     <= base_low  ^ q_entry.block[31:0];
      b     <= base_high ^ q_entry.block[63:32];
      total <= '0;
      ptext <= q_entry.block;
    end else if (step) begin
      a     <= a_next;
      b     <= b_next;
      total <= total_next;
    end
  end

  // Round counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= '0;
    end else if (step) begin
      count <= count + 1'b1;
    end
  end

  // Chaining value: ciphertext xor plaintext
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_low  <= '0;
      chain_high <= '0;
    end else if (load) begin
      chain_low  <= a ^ ptext[31:0];
      chain_high <= b ^ ptext[63:32];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      cipher_low  <= a;
      cipher_high <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== verif/xtea_pcbc_byte_encryptor_core_test.sv =====
// ---------------------------------------------------------------------------
// xtea_pcbc_byte_encryptor_core_test
// Self-checking bench for the XTEA PCBC byte encryptor. A directed table
// covers reset values, the byte extremes, zero rounds, the round count above
// its range, padding of partial blocks and empty ends. Random phases follow,
// each with a new round count and, by chance, new key and IV words. Each
// ciphertext is checked against a behavioural model or a known table result.
// ---------------------------------------------------------------------------
module xtea_pcbc_byte_encryptor_core_test;
  import xpbe_pkg::*;

  localparam int          RANDOM_ITEMS  = 500;
  localparam int          SETTLE_CYCLES = 300;
  localparam int          N_DIRECTED    = 34;
  localparam logic [2:0]  IDX_NONE      = 3'd7;

  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
  } cipher_t;

  typedef struct packed {
    logic        is_write;
    logic [2:0]  reg_index;
    logic [31:0] reg_value;
    logic        act;
    logic [7:0]  byte_in;
    logic        has_known;
    logic [31:0] known_low;
    logic [31:0] known_high;
  } stim_row_t;

  // Directed table: register writes and items; known results only where
  // zero rounds reduce the cipher to a plain XOR with the IV
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{1'b0, IDX_NONE,    32'h0,         ACT_END,  8'h00, 1'b0, 32'h0, 32'h0},
    '{1'b1, IDX_ROUNDS,  32'hFFFF_FE00, ACT_BYTE, 8'h00, 1'b0, 32'h0, 32'h0},
    '{1'b1, IDX_IV_LOW,  32'h0123_4567, ACT_BYTE, 8'h00, 1'b0, 32'h0, 32'h0},
    '{1'b1, IDX_IV_HIGH, 32'h89AB_CDEF, ACT_BYTE, 8'h00, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'h00, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'hFF, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'h55, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'hAA, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'h01, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'h80, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'h7F, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'hFE,
      1'b1, 32'hAB76_BA67, 32'h77D4_4DEE},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'h11, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'h22, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'h33, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_END,  8'hFF,
      1'b1, 32'h0110_6776, 32'h89AB_CDEF},
    '{1'b1, IDX_KEY0,    32'hFFFF_FFFF, ACT_BYTE, 8'h00, 1'b0, 32'h0, 32'h0},
    '{1'b1, IDX_KEY1,    32'h0000_0000, ACT_BYTE, 8'h00, 1'b0, 32'h0, 32'h0},
    '{1'b1, IDX_KEY2,    32'hA5A5_A5A5, ACT_BYTE, 8'h00, 1'b0, 32'h0, 32'h0},
    '{1'b1, IDX_KEY3,    32'h5A5A_5A5A, ACT_BYTE, 8'h00, 1'b0, 32'h0, 32'h0},
    '{1'b1, IDX_IV_LOW,  32'hFFFF_FFFF, ACT_BYTE, 8'h00, 1'b0, 32'h0, 32'h0},
    '{1'b1, IDX_IV_HIGH, 32'h0000_0000, ACT_BYTE, 8'h00, 1'b0, 32'h0, 32'h0},
    '{1'b1, IDX_ROUNDS,  32'h0000_012C, ACT_BYTE, 8'h00, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'h80, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'h01, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'hFF, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'h00, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'h7F, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'hFE, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'h55, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'hAA, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_END,  8'h00, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_BYTE, 8'h5A, 1'b0, 32'h0, 32'h0},
    '{1'b0, IDX_NONE,    32'h0,         ACT_END,  8'h5A, 1'b0, 32'h0, 32'h0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        action;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] cipher_low;
  logic [31:0] cipher_high;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // Model copy of the registers and the stream state
  logic [31:0] iv_lo_r;
  logic [31:0] iv_hi_r;
  logic [31:0] key_r [4];
  logic [8:0]  rounds_r;
  logic [31:0] chain_lo;
  logic [31:0] chain_hi;
  logic [55:0] held_bytes;
  int          held_count;
  bit          take_iv;

  cipher_t     cipher_q [$];
  int          mismatches = 0;
  bit          calm_input = 1'b0;
  bit          busy_since_settle = 1'b0;
  int          random_items = 0;
  int          stall_left = 0;
  int          out_cycles = 0;

  always #6 clk = ~clk;

  xtea_pcbc_byte_encryptor_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cipher_low  (cipher_low),
    .cipher_high (cipher_high),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Track a register write in the model
  function automatic void apply_config(input logic [2:0] idx, input logic [31:0] v);
    case (idx)
      IDX_IV_LOW:  iv_lo_r = v;
      IDX_IV_HIGH: iv_hi_r = v;
      IDX_KEY0:    key_r[0] = v;
      IDX_KEY1:    key_r[1] = v;
      IDX_KEY2:    key_r[2] = v;
      IDX_KEY3:    key_r[3] = v;
      IDX_ROUNDS:  rounds_r = v[8:0];
      default: ;
    endcase
  endfunction

  // XTEA encipher, round count clamped to the maximum
  function automatic void xtea_encipher(inout logic [31:0] v0, inout logic [31:0] v1);
    logic [31:0] sum;
    int          n;
    sum = 32'h0;
    n = (rounds_r > MAX_ROUNDS) ? int'(MAX_ROUNDS) : int'(rounds_r);
    for (int r = 0; r < n; r++) begin
      v0 += (((v1 << 4) ^ (v1 >> 5)) + v1) ^ (sum + key_r[sum[1:0]]);
      sum += XTEA_DELTA;
      v1 += (((v0 << 4) ^ (v0 >> 5)) + v0) ^ (sum + key_r[sum[12:11]]);
    end
  endfunction

  // Chain and encipher one block, PCBC style
  function automatic cipher_t seal_block(input logic [63:0] blk);
    cipher_t c;
    if (take_iv) begin
      chain_lo = iv_lo_r;
      chain_hi = iv_hi_r;
      take_iv  = 1'b0;
    end
    c.lo = chain_lo ^ blk[31:0];
    c.hi = chain_hi ^ blk[63:32];
    xtea_encipher(c.lo, c.hi);
    chain_lo = c.lo ^ blk[31:0];
    chain_hi = c.hi ^ blk[63:32];
    return c;
  endfunction

  // Advance the model by one item; return 1 when a ciphertext is due
  function automatic bit absorb_item(input logic act, input logic [7:0] b,
                                     output cipher_t res);
    logic [63:0] blk;
    res = '0;
    if (act == ACT_END) begin
      absorb_item = (held_count != 0);
      if (absorb_item)
        res = seal_block({8'h00, held_bytes});
      held_bytes = '0;
      held_count = 0;
      take_iv    = 1'b1;
    end else if (held_count < 7) begin
      held_bytes[held_count*8 +: 8] = b;
      held_count++;
      absorb_item = 1'b0;
    end else begin
      blk        = {b, held_bytes};
      held_bytes = '0;
      held_count = 0;
      res        = seal_block(blk);
      absorb_item = 1'b1;
    end
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_input || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Write one register at the next edge; the caller lowers the enable
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    apply_config(idx, v);
    @(posedge clk);
  endtask

  // Offer one item, hold it until taken, and queue its expected result
  task automatic send_item(input logic act, input logic [7:0] b, input bit known,
                           input logic [31:0] klo, input logic [31:0] khi);
    int      gap;
    cipher_t res;
    gap = pick_gap();
    cfg_write <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    data_byte <= b;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    if (absorb_item(act, b, res)) begin
      if (known) begin
        res.lo = klo;
        res.hi = khi;
      end
      cipher_q.push_back(res);
    end
    busy_since_settle = 1'b1;
    @(posedge clk);
  endtask

  // Drain all results, then let any result-less work finish
  task automatic settle_block();
    if (busy_since_settle) begin
      in_valid <= 1'b0;
      while (cipher_q.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      busy_since_settle = 1'b0;
    end
  endtask

  // Stimulus: reset, directed table, then random phases
  initial begin
    int          count;
    logic [31:0] v;
    rst       = 1'b1;
    in_valid  = 1'b0;
    action    = ACT_BYTE;
    data_byte = 8'h00;
    cfg_write = 1'b0;
    cfg_index = IDX_IV_LOW;
    cfg_data  = 32'h0;
    iv_lo_r   = '0;
    iv_hi_r   = '0;
    for (int k = 0; k < 4; k++) key_r[k] = '0;
    rounds_r   = MAX_ROUNDS;
    chain_lo   = '0;
    chain_hi   = '0;
    held_bytes = '0;
    held_count = 0;
    take_iv    = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].is_write) begin
        settle_block();
        write_reg(DIRECTED[i].reg_index, DIRECTED[i].reg_value);
      end else begin
        send_item(DIRECTED[i].act, DIRECTED[i].byte_in, DIRECTED[i].has_known,
                  DIRECTED[i].known_low, DIRECTED[i].known_high);
      end
    end

    // Random phases; a phase may stop mid-block so new IVs land mid-stream
    while (random_items < RANDOM_ITEMS) begin
      settle_block();
      for (cfg_idx_t k = IDX_IV_LOW; k != IDX_ROUNDS; k = k.next()) begin
        if ($urandom_range(0, 1) == 1) begin
          case ($urandom_range(0, 7))
            0:       v = 32'h0000_0000;
            1:       v = 32'hFFFF_FFFF;
            default: v = $urandom;
          endcase
          write_reg(k, v);
        end
      end
      v = $urandom;
      case ($urandom_range(0, 5))
        0:       v[8:0] = 9'd0;
        1:       v[8:0] = 9'd1;
        2:       v[8:0] = MAX_ROUNDS;
        3:       v[8:0] = 9'($urandom_range(257, 511));
        4:       v[8:0] = 9'($urandom_range(2, 40));
        default: v[8:0] = 9'($urandom_range(0, 511));
      endcase
      write_reg(IDX_ROUNDS, v);
      if ($urandom_range(0, 5) == 0)
        write_reg(IDX_NONE, $urandom);
      calm_input = ($urandom_range(0, 3) == 0);
      count = $urandom_range(16, 72);
      repeat (count) begin
        send_item(($urandom_range(0, 15) == 0) ? ACT_END : ACT_BYTE,
                  8'($urandom_range(0, 255)), 1'b0, 32'h0, 32'h0);
        random_items++;
      end
    end

    settle_block();
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Output stall: quiet windows, else mostly no stall, some short stalls and a few long ones
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      out_cycles++;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ((out_cycles / 1500) % 4 == 0) begin
        out_stall <= 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3: stall_left = $urandom_range(0, 2);
          4:          stall_left = $urandom_range(20, 60);
          default:    stall_left = -1;
        endcase
        out_stall <= (stall_left >= 0);
        if (stall_left < 0) stall_left = 0;
      end
    end
  end

  // Compare each taken result with the oldest expectation
  always @(negedge clk) begin : check_results
    cipher_t want;
    if (!rst && out_valid && !out_stall) begin
      if (cipher_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h %h", cipher_low, cipher_high));
      end else begin
        want = cipher_q.pop_front();
        if (cipher_low !== want.lo)
          flag_mismatch($sformatf("cipher_low %h, want %h", cipher_low, want.lo));
        if (cipher_high !== want.hi)
          flag_mismatch($sformatf("cipher_high %h, want %h", cipher_high, want.hi));
      end
    end
  end

  // Hard stop on a hang
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
